FILE: rtl/odestep_pkg.sv
// Shared types, constants and arithmetic helpers for the ODE stepper.
package odestep_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 11;
  localparam int unsigned FracW   = 24;
  localparam int unsigned WideW   = 41;
  localparam int unsigned DivW    = 36;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CountW-1:0] MaxSteps = 11'd1024;

  localparam logic [CfgIdxW-1:0] RegMethod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegXStart = 2'd1;
  localparam logic [CfgIdxW-1:0] RegXEnd   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCount  = 2'd3;

  localparam logic [1:0] MethEuler = 2'd0;
  localparam logic [1:0] MethRk2   = 2'd1;
  localparam logic [1:0] MethRk4   = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  // floor(2^32 / 6) and ceil(2^33 / 3) for the divide by 6
  localparam logic [DataW-1:0] SixthOf2p32 = 32'd715827882;
  localparam logic [DataW-1:0] Recip3      = 32'hAAAA_AAAB;

  typedef struct packed {
    logic                    opcode;
    logic signed [DataW-1:0] initial_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] x_value;
    logic signed [DataW-1:0] y_value;
    logic [CountW-1:0]       step_index;
    logic                    done_res;
  } out_word_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_HSET, DP_MSLOPE, DP_FLATCH, DP_MH, DP_KLATCH,
    DP_SUM, DP_D6PREP, DP_D6MUL, DP_FIN, DP_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] kidx;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       step_ok;
    logic       out_free;
    logic [1:0] method;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVH, ST_HSET, ST_MSLOPE, ST_FLATCH, ST_MH, ST_KLATCH,
    ST_SUM, ST_DIV6, ST_DIV6M, ST_FIN, ST_RES
  } ctrl_state_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(64'sh7FFF_FFFF);
    lo = -WideW'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[DataW-1:0];
  endfunction

  // halve toward zero
  function automatic logic signed [WideW-1:0] half_tz(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] t;
    t = v + WideW'(v[WideW-1]);
    return t >>> 1;
  endfunction

endpackage

FILE: rtl/odestep_if.sv
// Valid/ready channel interfaces for input and result words.
interface odestep_in_if import odestep_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface odestep_out_if import odestep_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/odestep_div.sv
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
module odestep_div import odestep_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic [CountW-1:0]     divisor_i,
  output logic                  busy_o,
  output logic signed [DivW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CountW:0]   rem_q, rem_d;
  logic [DivW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [CountW:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem_q[CountW-1:0], quo_q[DivW-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i[DivW-1] ? DivW'(-dividend_i) : dividend_i;
      dvs_d = divisor_i;
      cnt_d = CntW'(DivW);
      neg_d = dividend_i[DivW-1];
    end else if (cnt_q != '0) begin
      rem_d = fits ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = neg_q ? -signed'(quo_q) : signed'(quo_q);
endmodule

FILE: rtl/odestep_dp.sv
// Datapath: config, state, shared multiplier, k terms, divider and result register.
module odestep_dp import odestep_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DataW-1:0]     cfg_data_i,
  input  in_word_t             in_word_i,
  input  dp_cmd_t              cmd_i,
  input  logic                 out_ready_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  output out_word_t            out_word_o
);
  logic [1:0]              method_q;
  logic signed [DataW-1:0] xs_q, xe_q;
  logic [CountW-1:0]       count_q;
  logic signed [DataW-1:0] x_q, y_q, h_q, f_q;
  logic [CountW-1:0]       steps_q;
  logic signed [63:0]      p_q;
  logic signed [DataW-1:0] k_q [4];
  logic                    out_valid_q;
  out_word_t               out_q;
  logic signed [DivW-1:0]  acc_q;
  logic                    d6_neg_q;
  logic [DataW-1:0]        d6_u_q, d6_base_q;
  logic [63:0]             d6_prod_q;

  logic [CountW-1:0]       cnt_eff;
  logic signed [DataW-1:0] xh, xm, opx, opy, post_pos, post_neg;
  logic signed [64:0]      pw;
  logic signed [DivW-1:0]  acc, div_dend, quot;
  logic [CountW-1:0]       div_dvs;
  logic                    div_start, div_busy;
  logic signed [WideW-1:0] delta;
  logic [DivW-1:0]         acc_mag;
  logic [1:0]              d6_mh;
  logic [DataW:0]          d6_t;
  logic [DataW-1:0]        d6_u, d6_base, d6_mag;
  logic [2:0]              d6_cnt;

  always_comb begin
    if (count_q == '0) cnt_eff = CountW'(1);
    else if (count_q > MaxSteps) cnt_eff = MaxSteps;
    else cnt_eff = count_q;
  end

  assign xh = sat32(WideW'(x_q) + WideW'(h_q));
  assign xm = sat32(WideW'(x_q) + half_tz(WideW'(h_q)));

  // slope operands per k stage
  always_comb begin
    unique case (cmd_i.kidx)
      2'd0: begin
        opx = x_q;
        opy = y_q;
      end
      2'd1: begin
        if (method_q == MethRk2) begin
          opx = xh;
          opy = sat32(WideW'(y_q) + WideW'(k_q[0]));
        end else begin
          opx = xm;
          opy = sat32(WideW'(y_q) + half_tz(WideW'(k_q[0])));
        end
      end
      2'd2: begin
        opx = xm;
        opy = sat32(WideW'(y_q) + half_tz(WideW'(k_q[1])));
      end
      default: begin
        opx = xh;
        opy = sat32(WideW'(y_q) + WideW'(k_q[2]));
      end
    endcase
  end

  assign pw       = 65'(p_q);
  assign post_pos = sat32(WideW'(pw >>> FracW));
  assign post_neg = sat32(WideW'((-pw) >>> FracW));

  assign acc = DivW'(k_q[0]) + (DivW'(k_q[1]) <<< 1) + (DivW'(k_q[2]) <<< 1)
             + DivW'(k_q[3]);

  // divide the weighted sum by 6 toward zero: split off multiples of 2^32,
  // then a reciprocal multiply on the 32-bit remainder
  assign acc_mag = acc_q[DivW-1] ? DivW'(-acc_q) : DivW'(acc_q);
  assign d6_mh   = acc_mag[DataW+1:DataW];
  assign d6_t    = {1'b0, acc_mag[DataW-1:0]} + {{(DataW-3){1'b0}}, d6_mh, 2'b00};
  assign d6_u    = d6_t[DataW-1:0] + {{(DataW-3){1'b0}}, d6_t[DataW], 2'b00};
  assign d6_cnt  = {1'b0, d6_mh} + {2'b00, d6_t[DataW]};
  assign d6_base = DataW'(d6_cnt) * SixthOf2p32;
  assign d6_mag  = d6_base_q + {2'b00, d6_prod_q[63:34]};

  assign div_start = (cmd_i.op == DP_LOAD);
  assign div_dend  = DivW'(WideW'(xe_q) - WideW'(xs_q));
  assign div_dvs   = cnt_eff;

  odestep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_comb begin
    if (method_q == MethEuler) delta = WideW'(k_q[0]);
    else if (method_q == MethRk2) delta = half_tz(WideW'(k_q[0]) + WideW'(k_q[1]));
    else delta = d6_neg_q ? -WideW'({1'b0, d6_mag}) : WideW'({1'b0, d6_mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= MethRk4;
      xs_q        <= '0;
      xe_q        <= 32'sd83886080;
      count_q     <= 11'd100;
      x_q         <= '0;
      y_q         <= '0;
      h_q         <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMethod: method_q <= cfg_data_i[1:0];
          RegXStart: xs_q     <= cfg_data_i;
          RegXEnd:   xe_q     <= cfg_data_i;
          RegCount:  count_q  <= cfg_data_i[CountW-1:0];
          default:   ;
        endcase
      end
      if (cmd_i.op == DP_RES) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        DP_LOAD: begin
          y_q     <= in_word_i.initial_value;
          x_q     <= xs_q;
          steps_q <= '0;
        end
        DP_HSET: h_q <= sat32(WideW'(quot));
        DP_FIN: begin
          y_q     <= sat32(WideW'(y_q) + delta);
          x_q     <= xh;
          steps_q <= steps_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_MSLOPE: p_q <= 64'(opx) * 64'(opy);
      DP_FLATCH: f_q <= post_neg;
      DP_MH:     p_q <= 64'(h_q) * 64'(f_q);
      DP_KLATCH: k_q[cmd_i.kidx] <= post_pos;
      DP_SUM:    acc_q <= acc;
      DP_D6PREP: begin
        d6_u_q    <= d6_u;
        d6_base_q <= d6_base;
        d6_neg_q  <= acc_q[DivW-1];
      end
      DP_D6MUL:  d6_prod_q <= 64'(d6_u_q) * 64'(Recip3);
      DP_RES: begin
        out_q.x_value    <= x_q;
        out_q.y_value    <= y_q;
        out_q.step_index <= steps_q;
        out_q.done_res   <= steps_q >= cnt_eff;
      end
      default: ;
    endcase
  end

  assign status_o.div_busy = div_busy;
  assign status_o.step_ok  = steps_q < cnt_eff;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.method   = method_q;
  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_q;
endmodule

FILE: rtl/odestep_ctrl.sv
// Controller: sequences loads and integration steps through the datapath.
module odestep_ctrl import odestep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);
  ctrl_state_e state_q, state_d;
  logic [1:0]  kidx_q, kidx_d;
  logic [1:0]  klast;

  always_comb begin
    if (status_i.method == MethEuler) klast = 2'd0;
    else if (status_i.method == MethRk2) klast = 2'd1;
    else klast = 2'd3;
  end

  always_comb begin
    state_d = state_q;
    kidx_d  = kidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kidx_d = 2'd0;
          if (in_opcode_i == OpLoad) state_d = ST_DIVH;
          else if (status_i.step_ok) state_d = ST_MSLOPE;
          else state_d = ST_RES;
        end
      end
      ST_DIVH:   if (!status_i.div_busy) state_d = ST_HSET;
      ST_HSET:   state_d = ST_RES;
      ST_MSLOPE: state_d = ST_FLATCH;
      ST_FLATCH: state_d = ST_MH;
      ST_MH:     state_d = ST_KLATCH;
      ST_KLATCH: begin
        if (kidx_q == klast) begin
          state_d = ST_SUM;
        end else begin
          kidx_d  = kidx_q + 1'b1;
          state_d = ST_MSLOPE;
        end
      end
      ST_SUM:   state_d = (klast == 2'd3) ? ST_DIV6 : ST_FIN;
      ST_DIV6:  state_d = ST_DIV6M;
      ST_DIV6M: state_d = ST_FIN;
      ST_FIN:   state_d = ST_RES;
      ST_RES:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.kidx = kidx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_opcode_i == OpLoad) cmd_o.op = DP_LOAD;
      end
      ST_HSET:   cmd_o.op = DP_HSET;
      ST_MSLOPE: cmd_o.op = DP_MSLOPE;
      ST_FLATCH: cmd_o.op = DP_FLATCH;
      ST_MH:     cmd_o.op = DP_MH;
      ST_KLATCH: cmd_o.op = DP_KLATCH;
      ST_SUM:    cmd_o.op = DP_SUM;
      ST_DIV6:   cmd_o.op = DP_D6PREP;
      ST_DIV6M:  cmd_o.op = DP_D6MUL;
      ST_FIN:    cmd_o.op = DP_FIN;
      ST_RES:    if (status_i.out_free) cmd_o.op = DP_RES;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      kidx_q  <= kidx_d;
    end
  end
endmodule

FILE: rtl/ode_stepper_euler_rk2_rk4_core.sv
// Top level: Euler / RK2 / RK4 stepper for dy/dx = -x*y in Q8.24.
// Load word: serial divide for h = (x_end - x_start) / count, then result register.
// Step word: k terms on the shared 32x32 multiplier, one for Euler, two for RK2,
//   four for RK4 plus divide by 6 by reciprocal. Past the last step: result only.
// One word in flight; the next word is taken the cycle after the result is
//   written, while that result waits in the output register.
// Reset (async, active low) clears state and sets config to its defaults.
module ode_stepper_euler_rk2_rk4_core import odestep_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  odestep_in_if.sink          in_i,
  odestep_out_if.source       out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DataW-1:0]    cfg_data_i
);
  dp_cmd_t    cmd;
  dp_status_t status;

  odestep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.payload.opcode),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  odestep_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_i.payload),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.payload)
  );

  a_no_accept_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !status.div_busy)
    else $error("word accepted while divider busy");

  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_RES) |-> status.out_free)
    else $error("result written over a pending word");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.step_index <= MaxSteps))
    else $error("step index above limit");
endmodule
